FILE: rtl/als_pkg.sv
`default_nettype none
package als_pkg;

  localparam int MAX_LEDS_DEF = 16;
  localparam int CNT_W        = 5;
  localparam int IDX_W        = 4;
  localparam int COLOR_W      = 8;
  localparam int TICK_W       = 8;
  localparam int GAP_W        = 16;
  localparam int PIXEL_W      = 3 * COLOR_W;
  localparam int BIT_POS_W    = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [BIT_POS_W-1:0] LAST_BIT = BIT_POS_W'(PIXEL_W - 1);

  localparam logic [CNT_W-1:0]  CHAIN_LEN_RST  = 5'd16;
  localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 8'd4;
  localparam logic [TICK_W-1:0] ZERO_LOW_RST   = 8'd9;
  localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 8'd8;
  localparam logic [TICK_W-1:0] ONE_LOW_RST    = 8'd5;
  localparam logic [GAP_W-1:0]  RESET_GAP_RST  = 16'd1000;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_SET   = 3'd1,
    OP_FILL  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_START = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_BUSY      = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHAIN_LEN   = 3'd0,
    REG_ZERO_HIGH   = 3'd1,
    REG_ZERO_LOW    = 3'd2,
    REG_ONE_HIGH    = 3'd3,
    REG_ONE_LOW     = 3'd4,
    REG_RESET_TICKS = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_GAP  = 2'd2
  } wave_phase_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_FILL = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic    tick;
    logic    set_wr;
    logic    fill_start;
    logic    fill_wr;
    logic    clear;
    logic    start;
    logic    out_load;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic sending;
    logic idx_bad;
    logic fill_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/als_ctrl.sv
`default_nettype none
module als_ctrl
  import als_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [2:0] op_i,
  input  wire dp_status_t dp_status_i,
  output logic            in_ready_o,
  output cmd_t            cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.status = ST_OK;
    in_ready_o = (state_q == CS_IDLE) && dp_status_i.out_free;
    accept     = in_valid_i && in_ready_o;
    case (state_q)
      CS_IDLE: begin
        if (accept) begin
          case (op_e'(op_i))
            OP_TICK: begin
              cmd_o.tick     = 1'b1;
              cmd_o.out_load = 1'b1;
            end
            OP_SET: begin
              cmd_o.out_load = 1'b1;
              if (dp_status_i.sending) begin
                cmd_o.status = ST_BUSY;
              end else if (dp_status_i.idx_bad) begin
                cmd_o.status = ST_BAD_INDEX;
              end else begin
                cmd_o.set_wr = 1'b1;
              end
            end
            OP_FILL: begin
              if (dp_status_i.sending) begin
                cmd_o.out_load = 1'b1;
                cmd_o.status   = ST_BUSY;
              end else begin
                cmd_o.fill_start = 1'b1;
                state_d          = CS_FILL;
              end
            end
            OP_CLEAR: begin
              cmd_o.out_load = 1'b1;
              if (dp_status_i.sending) begin
                cmd_o.status = ST_BUSY;
              end else begin
                cmd_o.clear = 1'b1;
              end
            end
            OP_START: begin
              cmd_o.out_load = 1'b1;
              if (dp_status_i.sending) begin
                cmd_o.status = ST_BUSY;
              end else begin
                cmd_o.start = 1'b1;
              end
            end
            default: begin
              cmd_o.out_load = 1'b1;
            end
          endcase
        end
      end
      CS_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (dp_status_i.fill_last) begin
          cmd_o.out_load = 1'b1;
          state_d        = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/als_datapath.sv
`default_nettype none
module als_datapath
  import als_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [IDX_W-1:0]      led_index_i,
  input  wire logic [COLOR_W-1:0]    red_i,
  input  wire logic [COLOR_W-1:0]    green_i,
  input  wire logic [COLOR_W-1:0]    blue_i,
  input  wire cmd_t                  cmd_i,
  input  wire logic                  out_ready_i,
  output dp_status_t                 dp_status_o,
  output logic                       out_valid_o,
  output logic                       data_line_o,
  output logic                       busy_res_o,
  output logic [1:0]                 status_o
);

  localparam int CNT_MAX     = (1 << CNT_W) - 1;
  localparam int STORE_DEPTH = (MAX_LEDS > CNT_MAX) ? CNT_MAX : MAX_LEDS;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(STORE_DEPTH);

  logic [CNT_W-1:0]  chain_len_q;
  logic [TICK_W-1:0] zero_high_q, zero_low_q, one_high_q, one_low_q;
  logic [GAP_W-1:0]  reset_ticks_q;

  logic [PIXEL_W-1:0] store_q [STORE_DEPTH];

  logic               sending_q, sending_d;
  wave_phase_e        phase_q, phase_d;
  logic [GAP_W-1:0]   pc_q, pc_d;
  logic [BIT_POS_W-1:0] bit_pos_q, bit_pos_d;
  logic [CNT_W-1:0]   led_pos_q, led_pos_d;
  logic [PIXEL_W-1:0] shift_q, shift_d;

  logic [CNT_W-1:0]   fill_cnt_q;
  logic [PIXEL_W-1:0] fill_color_q;

  logic               out_valid_q;
  logic               line_q, busy_q;
  status_e            status_q;

  logic [CNT_W-1:0]   count_min1, eff_count;
  logic [TICK_W-1:0]  high_sel, low_sel, high_dur, low_dur;
  logic [GAP_W-1:0]   gap_dur, pc_inc;
  logic [CNT_W:0]     led_next, fill_next;
  logic [PIXEL_W-1:0] next_pixel, in_pixel;

  assign count_min1 = (chain_len_q == '0) ? CNT_W'(1) : chain_len_q;
  assign eff_count  = (count_min1 > CNT_CAP) ? CNT_CAP : count_min1;
  assign in_pixel   = {green_i, red_i, blue_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_len_q   <= CHAIN_LEN_RST;
      zero_high_q   <= ZERO_HIGH_RST;
      zero_low_q    <= ZERO_LOW_RST;
      one_high_q    <= ONE_HIGH_RST;
      one_low_q     <= ONE_LOW_RST;
      reset_ticks_q <= RESET_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CHAIN_LEN:   chain_len_q   <= cfg_data_i[CNT_W-1:0];
        REG_ZERO_HIGH:   zero_high_q   <= cfg_data_i[TICK_W-1:0];
        REG_ZERO_LOW:    zero_low_q    <= cfg_data_i[TICK_W-1:0];
        REG_ONE_HIGH:    one_high_q    <= cfg_data_i[TICK_W-1:0];
        REG_ONE_LOW:     one_low_q     <= cfg_data_i[TICK_W-1:0];
        REG_RESET_TICKS: reset_ticks_q <= cfg_data_i[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else if (cmd_i.set_wr) begin
      store_q[AW'(led_index_i)] <= in_pixel;
    end else if (cmd_i.fill_wr) begin
      store_q[fill_cnt_q[AW-1:0]] <= fill_color_q;
    end
  end

  assign fill_next = {1'b0, fill_cnt_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q <= '0;
    end else if (cmd_i.fill_start) begin
      fill_cnt_q <= '0;
    end else if (cmd_i.fill_wr) begin
      fill_cnt_q <= fill_next[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_start) begin
      fill_color_q <= in_pixel;
    end
  end

  assign high_sel = shift_q[PIXEL_W-1] ? one_high_q : zero_high_q;
  assign low_sel  = shift_q[PIXEL_W-1] ? one_low_q : zero_low_q;
  assign high_dur = (high_sel == '0) ? TICK_W'(1) : high_sel;
  assign low_dur  = (low_sel == '0) ? TICK_W'(1) : low_sel;
  assign gap_dur  = (reset_ticks_q == '0) ? GAP_W'(1) : reset_ticks_q;
  assign pc_inc   = pc_q + 1'b1;
  assign led_next = {1'b0, led_pos_q} + 1'b1;
  assign next_pixel = (led_next < (CNT_W+1)'(STORE_DEPTH)) ? store_q[led_next[AW-1:0]] : '0;

  always_comb begin
    sending_d = sending_q;
    phase_d   = phase_q;
    pc_d      = pc_q;
    bit_pos_d = bit_pos_q;
    led_pos_d = led_pos_q;
    shift_d   = shift_q;
    if (cmd_i.start) begin
      sending_d = 1'b1;
      phase_d   = PH_HIGH;
      pc_d      = '0;
      bit_pos_d = '0;
      led_pos_d = '0;
      shift_d   = store_q[0];
    end else if (cmd_i.tick && sending_q) begin
      case (phase_q)
        PH_HIGH: begin
          if (pc_inc >= {{(GAP_W-TICK_W){1'b0}}, high_dur}) begin
            pc_d    = '0;
            phase_d = PH_LOW;
          end else begin
            pc_d = pc_inc;
          end
        end
        PH_LOW: begin
          if (pc_inc >= {{(GAP_W-TICK_W){1'b0}}, low_dur}) begin
            pc_d    = '0;
            shift_d = {shift_q[PIXEL_W-2:0], 1'b0};
            phase_d = PH_HIGH;
            if (bit_pos_q >= LAST_BIT) begin
              bit_pos_d = '0;
              if (led_next >= {1'b0, eff_count}) begin
                phase_d = PH_GAP;
              end else begin
                led_pos_d = led_next[CNT_W-1:0];
                shift_d   = next_pixel;
              end
            end else begin
              bit_pos_d = bit_pos_q + 1'b1;
            end
          end else begin
            pc_d = pc_inc;
          end
        end
        default: begin
          if (pc_inc >= gap_dur) begin
            sending_d = 1'b0;
            phase_d   = PH_HIGH;
            pc_d      = '0;
            led_pos_d = '0;
            bit_pos_d = '0;
          end else begin
            pc_d = pc_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      phase_q   <= PH_HIGH;
      pc_q      <= '0;
      bit_pos_q <= '0;
      led_pos_q <= '0;
      shift_q   <= '0;
    end else begin
      sending_q <= sending_d;
      phase_q   <= phase_d;
      pc_q      <= pc_d;
      bit_pos_q <= bit_pos_d;
      led_pos_q <= led_pos_d;
      shift_q   <= shift_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      line_q   <= sending_d && (phase_d == PH_HIGH);
      busy_q   <= sending_d;
      status_q <= cmd_i.status;
    end
  end

  assign dp_status_o.sending   = sending_q;
  assign dp_status_o.idx_bad   = {1'b0, led_index_i} >= eff_count;
  assign dp_status_o.fill_last = fill_next >= {1'b0, eff_count};
  assign dp_status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign data_line_o = line_q;
  assign busy_res_o  = busy_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_gap_bit_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sending_q && (phase_q == PH_GAP)) |-> (bit_pos_q == '0))
    else $error("bit position not cleared in latch gap");
  a_idle_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> ((phase_q == PH_HIGH) && (pc_q == '0)))
    else $error("wave state not parked while idle");
  a_bit_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_pos_q <= LAST_BIT)
    else $error("bit position past last bit");
  a_no_store_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fill_wr || cmd_i.set_wr || cmd_i.clear) |-> !sending_q)
    else $error("store written during frame");
`endif

endmodule
`default_nettype wire

FILE: rtl/addressable_led_serializer_unit.sv
// Addressable LED serializer: one-wire GRB frame driver with a colour store.
// Input channel (in_valid_i/in_ready_o) takes one command word: tick, set one
// LED, fill, clear or start frame, with led_index_i and the colour fields.
// Output channel (out_valid_o/out_ready_i) returns one word per command:
// line level and busy flag after the command, and a status code.
// Each command's word appears in the cycle after acceptance, from an output
// register; tick, set, clear and start are each done at acceptance, so ticks can
// be issued every cycle while the receiver takes each word. Fill writes one store
// entry per cycle up to the effective LED count; its word appears at the last write.
// A new command is taken while the previous word is read in the same cycle;
// while the receiver stalls with a word pending, in_ready_o stays low.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i with no
// wait. Reset clears the colour store, stops any frame, restores the default
// timing registers and empties the output register.
`default_nettype none
module addressable_led_serializer_unit
  import als_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [2:0]            op_i,
  input  wire logic [IDX_W-1:0]      led_index_i,
  input  wire logic [COLOR_W-1:0]    red_i,
  input  wire logic [COLOR_W-1:0]    green_i,
  input  wire logic [COLOR_W-1:0]    blue_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       data_line_o,
  output logic                       busy_res_o,
  output logic [1:0]                 status_o
);

  cmd_t       cmd;
  dp_status_t dp_status;

  als_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .dp_status_i (dp_status),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  als_datapath #(
    .MAX_LEDS (MAX_LEDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .led_index_i (led_index_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .dp_status_o (dp_status),
    .out_valid_o (out_valid_o),
    .data_line_o (data_line_o),
    .busy_res_o  (busy_res_o),
    .status_o    (status_o)
  );

endmodule
`default_nettype wire

FILE: bench/addressable_led_serializer_unit_test.sv
`timescale 1ns / 1ps

import als_pkg::*;

typedef struct packed {
  logic    line;
  logic    busy;
  status_e status;
} line_word_t;

class led_scoreboard;
  logic [PIXEL_W-1:0] pixels [MAX_LEDS_DEF];
  bit                 sending;
  int                 led_pos;
  int                 bit_pos;
  logic [1:0]         phase;
  logic [GAP_W-1:0]   phase_cnt;
  logic [PIXEL_W-1:0] shifter;

  logic [CNT_W-1:0]   chain_len;
  logic [TICK_W-1:0]  zero_high;
  logic [TICK_W-1:0]  zero_low;
  logic [TICK_W-1:0]  one_high;
  logic [TICK_W-1:0]  one_low;
  logic [GAP_W-1:0]   gap_ticks;

  line_word_t         expected_q [$];
  int                 errors;

  function new();
    foreach (pixels[i]) pixels[i] = '0;
    sending   = 1'b0;
    led_pos   = 0;
    bit_pos   = 0;
    phase     = PH_HIGH;
    phase_cnt = '0;
    shifter   = '0;
    chain_len = CHAIN_LEN_RST;
    zero_high = ZERO_HIGH_RST;
    zero_low  = ZERO_LOW_RST;
    one_high  = ONE_HIGH_RST;
    one_low   = ONE_LOW_RST;
    gap_ticks = RESET_GAP_RST;
    errors    = 0;
  endfunction

  function int floor_one(int v);
    return (v == 0) ? 1 : v;
  endfunction

  function int live_count();
    int c;
    c = floor_one(chain_len);
    return (c > MAX_LEDS_DEF) ? MAX_LEDS_DEF : c;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_CHAIN_LEN:   chain_len = val[CNT_W-1:0];
      REG_ZERO_HIGH:   zero_high = val[TICK_W-1:0];
      REG_ZERO_LOW:    zero_low  = val[TICK_W-1:0];
      REG_ONE_HIGH:    one_high  = val[TICK_W-1:0];
      REG_ONE_LOW:     one_low   = val[TICK_W-1:0];
      REG_RESET_TICKS: gap_ticks = val[GAP_W-1:0];
      default: ;
    endcase
  endfunction

  function void advance_wave();
    int   dur;
    logic one;
    one       = shifter[PIXEL_W-1];
    phase_cnt = phase_cnt + 1'b1;
    if (phase == PH_HIGH) begin
      dur = floor_one(one ? one_high : zero_high);
      if (phase_cnt >= dur) begin
        phase_cnt = '0;
        phase     = PH_LOW;
      end
    end else if (phase == PH_LOW) begin
      dur = floor_one(one ? one_low : zero_low);
      if (phase_cnt >= dur) begin
        phase_cnt = '0;
        shifter   = shifter << 1;
        bit_pos++;
        phase     = PH_HIGH;
        if (bit_pos >= PIXEL_W) begin
          bit_pos = 0;
          if (led_pos + 1 >= live_count()) begin
            phase = PH_GAP;
          end else begin
            led_pos++;
            shifter = pixels[led_pos];
          end
        end
      end
    end else if (phase_cnt >= floor_one(gap_ticks)) begin
      sending   = 1'b0;
      phase     = PH_HIGH;
      phase_cnt = '0;
      led_pos   = 0;
      bit_pos   = 0;
    end
  endfunction

  function void note_word(logic [2:0] op, logic [IDX_W-1:0] idx,
                          logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                          logic [COLOR_W-1:0] b);
    line_word_t w;
    status_e    st;
    st = ST_OK;
    if (op == OP_TICK) begin
      if (sending) advance_wave();
    end else if (op >= OP_SET && op <= OP_START && sending) begin
      st = ST_BUSY;
    end else if (op == OP_SET) begin
      if (idx >= live_count()) st = ST_BAD_INDEX;
      else pixels[idx] = {g, r, b};
    end else if (op == OP_FILL) begin
      for (int i = 0; i < live_count(); i++) pixels[i] = {g, r, b};
    end else if (op == OP_CLEAR) begin
      foreach (pixels[i]) pixels[i] = '0;
    end else if (op == OP_START) begin
      sending   = 1'b1;
      led_pos   = 0;
      bit_pos   = 0;
      phase     = PH_HIGH;
      phase_cnt = '0;
      shifter   = pixels[0];
    end
    w.line   = sending && (phase == PH_HIGH);
    w.busy   = sending;
    w.status = st;
    expected_q.push_back(w);
  endfunction

  function void check_word(logic line, logic busy, logic [1:0] status);
    line_word_t w;
    if (expected_q.size() == 0) begin
      $display("%0t: word with nothing expected (line %0d busy %0d status %0d)",
               $time, line, busy, status);
      errors++;
      return;
    end
    w = expected_q.pop_front();
    if (line !== w.line) begin
      $display("%0t: data_line expected %0d got %0d", $time, w.line, line);
      errors++;
    end
    if (busy !== w.busy) begin
      $display("%0t: busy_res expected %0d got %0d", $time, w.busy, busy);
      errors++;
    end
    if (status !== w.status) begin
      $display("%0t: status expected %0d got %0d", $time, w.status, status);
      errors++;
    end
  endfunction
endclass

module addressable_led_serializer_unit_test;

  localparam logic [2:0]           OP_UNUSED_LO = 3'd5;
  localparam logic [2:0]           OP_UNUSED_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;
  localparam int                   PHASES       = 15;
  localparam int                   PHASE_WORDS  = 100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [2:0]            op_i;
  logic [IDX_W-1:0]      led_index_i;
  logic [COLOR_W-1:0]    red_i;
  logic [COLOR_W-1:0]    green_i;
  logic [COLOR_W-1:0]    blue_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  data_line_o;
  logic                  busy_res_o;
  logic [1:0]            status_o;

  led_scoreboard sb;
  int            words_seen;

  addressable_led_serializer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .led_index_i (led_index_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_line_o (data_line_o),
    .busy_res_o  (busy_res_o),
    .status_o    (status_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                           input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                           input logic [COLOR_W-1:0] b, input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    op_i        = op;
    led_index_i = idx;
    red_i       = r;
    green_i     = g;
    blue_i      = b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(op, idx, r, g, b);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] with_noise(int width, int val);
    logic [CFG_DATA_W-1:0] mask;
    mask = (CFG_DATA_W'(1) << width) - 1'b1;
    return (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(val) & mask);
  endfunction

  function automatic int pick_tick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(9, 255);
  endfunction

  task automatic configure_phase(input int ph);
    int r;
    int cnt;
    int gap;
    if (ph == 4) begin
      write_reg(REG_CHAIN_LEN, with_noise(CNT_W, MAX_LEDS_DEF));
      write_reg(REG_ZERO_HIGH, with_noise(TICK_W, 255));
      write_reg(REG_ZERO_LOW, with_noise(TICK_W, 255));
      write_reg(REG_ONE_HIGH, with_noise(TICK_W, 255));
      write_reg(REG_ONE_LOW, with_noise(TICK_W, 255));
      write_reg(REG_RESET_TICKS, 16'hFFFF);
    end else if (ph == 9) begin
      write_reg(REG_CHAIN_LEN, with_noise(CNT_W, 0));
      write_reg(REG_ZERO_HIGH, with_noise(TICK_W, 0));
      write_reg(REG_ZERO_LOW, with_noise(TICK_W, 0));
      write_reg(REG_ONE_HIGH, with_noise(TICK_W, 0));
      write_reg(REG_ONE_LOW, with_noise(TICK_W, 0));
      write_reg(REG_RESET_TICKS, '0);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) cnt = 1;
      else if (r < 85) cnt = $urandom_range(2, 4);
      else if (r < 90) cnt = 0;
      else if (r < 95) cnt = MAX_LEDS_DEF;
      else cnt = $urandom_range(MAX_LEDS_DEF + 1, 31);
      r = $urandom_range(0, 99);
      if (r < 70) gap = $urandom_range(1, 20);
      else if (r < 85) gap = 0;
      else if (r < 95) gap = $urandom_range(21, 300);
      else gap = 65535;
      write_reg(REG_CHAIN_LEN, with_noise(CNT_W, cnt));
      write_reg(REG_ZERO_HIGH, with_noise(TICK_W, pick_tick_len()));
      write_reg(REG_ZERO_LOW, with_noise(TICK_W, pick_tick_len()));
      write_reg(REG_ONE_HIGH, with_noise(TICK_W, pick_tick_len()));
      write_reg(REG_ONE_LOW, with_noise(TICK_W, pick_tick_len()));
      write_reg(REG_RESET_TICKS, CFG_DATA_W'(gap));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word(data_line_o, busy_res_o, status_o);
      words_seen++;
    end
  end

  initial begin
    int run_len;
    int holds_done;
    holds_done  = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      run_len = $urandom_range(1, 40);
      repeat (run_len) begin
        @(negedge clk_i);
        out_ready_i = 1'b1;
      end
      if (holds_done < 2 && words_seen >= 400 + 700 * holds_done) begin
        holds_done++;
        repeat (300) begin
          @(negedge clk_i);
          out_ready_i = 1'b0;
        end
      end else begin
        repeat (pick_gap()) begin
          @(negedge clk_i);
          out_ready_i = 1'b0;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("addressable_led_serializer_unit test failed");
    $finish;
  end

  initial begin
    bit               steady;
    int               r;
    logic [2:0]       op;
    logic [IDX_W-1:0] idx;

    sb          = new();
    words_seen  = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    op_i        = OP_TICK;
    led_index_i = '0;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(OP_TICK, '0, '0, '0, '0, 0);
    send_word(OP_SET, 4'd0, 8'hFF, 8'h00, 8'hFF, pick_gap());
    send_word(OP_SET, 4'd15, 8'h00, 8'hFF, 8'h00, pick_gap());
    send_word(OP_SET, 4'd7, 8'h00, 8'h00, 8'h00, pick_gap());
    for (int u = OP_UNUSED_LO; u <= OP_UNUSED_HI; u++)
      send_word(3'(u), 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 0);
    send_word(OP_FILL, '0, 8'hFF, 8'hFF, 8'hFF, 0);
    send_word(OP_CLEAR, '0, '0, '0, '0, 0);
    write_reg(REG_CHAIN_LEN, '0);
    send_word(OP_SET, 4'd1, 8'h11, 8'h22, 8'h33, 0);
    send_word(OP_SET, 4'd0, 8'h5A, 8'hA5, 8'hC3, 0);
    write_reg(REG_CHAIN_LEN, 16'hFFFF);
    send_word(OP_SET, 4'd15, 8'hFF, 8'hFF, 8'hFF, 0);
    write_reg(REG_CHAIN_LEN, 16'd3);
    send_word(OP_SET, 4'd3, 8'h01, 8'h02, 8'h03, 0);
    send_word(OP_FILL, '0, 8'h12, 8'h34, 8'h56, 0);
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_CHAIN_LEN, 16'd1);
    write_reg(REG_ZERO_HIGH, '0);
    write_reg(REG_ZERO_LOW, '0);
    write_reg(REG_ONE_HIGH, '0);
    write_reg(REG_ONE_LOW, '0);
    write_reg(REG_RESET_TICKS, '0);
    send_word(OP_START, '0, '0, '0, '0, 0);
    send_word(OP_SET, 4'd0, 8'hFF, 8'hFF, 8'hFF, 0);
    send_word(OP_FILL, '0, 8'hFF, 8'hFF, 8'hFF, 0);
    send_word(OP_CLEAR, '0, '0, '0, '0, 0);
    send_word(OP_START, '0, '0, '0, '0, 0);
    repeat (4) send_word(OP_TICK, '0, '0, '0, '0, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      steady = ($urandom_range(0, 3) == 0);
      configure_phase(ph);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        r = $urandom_range(0, 99);
        if (sb.sending) begin
          if (r < 88) op = OP_TICK;
          else if (r < 90) op = OP_SET;
          else if (r < 92) op = OP_FILL;
          else if (r < 94) op = OP_CLEAR;
          else if (r < 97) op = OP_START;
          else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end else begin
          if (r < 20) op = OP_TICK;
          else if (r < 50) op = OP_SET;
          else if (r < 60) op = OP_FILL;
          else if (r < 65) op = OP_CLEAR;
          else if (r < 85) op = OP_START;
          else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        if ($urandom_range(0, 3) != 0) idx = IDX_W'($urandom_range(0, sb.live_count() - 1));
        else idx = IDX_W'($urandom);
        send_word(op, idx, 8'($urandom), 8'($urandom), 8'($urandom),
                  steady ? 0 : pick_gap());
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("addressable_led_serializer_unit test passed");
    end else begin
      $display("addressable_led_serializer_unit test failed");
    end
    $finish;
  end

endmodule
